FILE: design/gcst_pkg.sv
// shared constants, codes and state type for the gap cluster size table
`timescale 1ns / 1ps
`default_nettype none

package gcst_pkg;

  // default table geometry
  localparam int CAPACITY_DEF   = 256;
  localparam int COORD_BITS_DEF = 32;

  // fixed field widths
  localparam int POINT_W = 32;
  localparam int GAP_W   = 32;
  localparam int SIZE_W  = 9;

  // request kinds
  localparam logic REQ_TOGGLE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_PROBE,
    ST_PCHK,
    ST_DEL,
    ST_DELW,
    ST_INS,
    ST_INSW,
    ST_QLD,
    ST_QLDW,
    ST_QBACK,
    ST_QBCHK,
    ST_QFWD,
    ST_QFCHK,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: design/gcst_req_if.sv
// request channel: valid/ready handshake carrying one toggle or query item
`timescale 1ns / 1ps
`default_nettype none

interface gcst_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [gcst_pkg::POINT_W-1:0] point;

  modport source (output valid, output req_type, output point, input ready);
  modport sink   (input valid, input req_type, input point, output ready);
endinterface

`default_nettype wire

FILE: design/gcst_rsp_if.sv
// response channel: valid/ready handshake carrying one result item
`timescale 1ns / 1ps
`default_nettype none

interface gcst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gcst_pkg::SIZE_W-1:0] cluster_size;
  logic                        rejected;

  modport source (output valid, output cluster_size, output rejected, input ready);
  modport sink   (input valid, input cluster_size, input rejected, output ready);
endinterface

`default_nettype wire

FILE: design/gap_cluster_size_table_core.sv
// sorted point table with toggle insert/remove and gap cluster size queries
//
// Usage: items arrive on req (req_type 0 toggles point in or out, 1 queries
// the size of the cluster at or just below point); one result item per
// request leaves on rsp. gap_limit is written through cfg_we/cfg_wdata; the
// user must write it only while the block is idle, which the block itself does
// not enforce. One item is worked on at a time; req.ready is high only when
// the sequencer is idle. Steps of an item, with n points stored:
//   binary search  : one table RAM read and compare per probe
//   hit check      : fetch and compare the entry at the insertion point
//   remove         : n-pos-1 entries moved down, one RAM read and write each
//   insert         : n-pos entries moved up, then p written in
//   query          : load the start point, walk down then up one neighbor
//                    at a time until both cluster ends are found
//   result         : held in the output state until rsp.ready
// Steps run in series on the single-port-read table RAM and the one
// subtract/compare unit. A stalled receiver simply holds the block in ST_OUT.
// Reset (rst, synchronous) empties the table and clears gap_limit at once;
// table RAM contents are not cleared and no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module gap_cluster_size_table_core #(
  parameter int CAPACITY   = gcst_pkg::CAPACITY_DEF,
  parameter int COORD_BITS = gcst_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  gcst_req_if.sink                          req,
  gcst_rsp_if.source                        rsp,
  input  wire logic                         cfg_we,
  input  wire logic [gcst_pkg::GAP_W-1:0]   cfg_wdata
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT  = $clog2(CAPACITY + 1);
  localparam int CNT1 = CNT + 1;
  localparam int CW   = COORD_BITS;
  localparam int PW   = gcst_pkg::POINT_W;
  localparam int GW   = gcst_pkg::GAP_W;
  localparam int SW   = gcst_pkg::SIZE_W;

  // table ram
  logic [CW-1:0] mem [CAPACITY];
  logic [CW-1:0] rd_data;
  logic [IW-1:0] mem_raddr;
  logic [IW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic          mem_we;

  // control and data registers
  gcst_pkg::state_t state, state_next;
  logic           kind, kind_next;
  logic [CW-1:0]  p, p_next;
  logic [CNT-1:0] lo, lo_next;
  logic [CNT-1:0] hi, hi_next;
  logic [CNT-1:0] mid, mid_next;
  logic [CNT-1:0] pos, pos_next;
  logic [CNT-1:0] idx, idx_next;
  logic [CNT-1:0] occ, occ_next;
  logic [IW-1:0]  s_idx, s_idx_next;
  logic [IW-1:0]  e_idx, e_idx_next;
  logic [CW-1:0]  cur, cur_next;
  logic [CW-1:0]  ecur, ecur_next;
  logic [CNT-1:0] size, size_next;
  logic           rej, rej_next;
  logic [GW-1:0]  gap_limit;

  // helper values
  logic [CW+PW-1:0] point_wide;
  logic [CW-1:0]    p_in;
  logic [CNT1-1:0]  mid_sum;
  logic [CNT1-1:0]  idx_inc;
  logic [CNT-1:0]   idx_dec;
  logic [IW-1:0]    s_dec;
  logic [CNT1-1:0]  e_inc;
  logic [CNT-1:0]   top;
  logic [CNT-1:0]   top_dec;
  logic             hit;
  logic [CNT+SW-1:0] size_wide;

  // shared subtract and compare unit
  logic [CW-1:0]    alu_a, alu_b;
  logic [CW:0]      alu_diff;
  logic             alu_lt;
  logic             alu_eq;
  logic             alu_joined;

  // point truncated or extended to the coordinate width
  assign point_wide = {{CW{1'b0}}, req.point};
  assign p_in       = point_wide[CW-1:0];

  assign mid_sum = (CNT1'(lo) + CNT1'(hi)) >> 1;
  assign idx_inc = CNT1'(idx) + CNT1'(1);
  assign idx_dec = idx - CNT'(1);
  assign s_dec   = s_idx - IW'(1);
  assign e_inc   = CNT1'(e_idx) + CNT1'(1);
  assign hit     = (pos < occ) && alu_eq;
  assign top     = hit ? (pos + CNT'(1)) : pos;
  assign top_dec = top - CNT'(1);

  // one subtractor serves the search compare and both gap checks
  always_comb begin
    unique case (state)
      gcst_pkg::ST_QBCHK: begin
        alu_a = cur;
        alu_b = rd_data;
      end
      gcst_pkg::ST_QFCHK: begin
        alu_a = rd_data;
        alu_b = ecur;
      end
      default: begin
        alu_a = rd_data;
        alu_b = p;
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt     = alu_diff[CW];
  assign alu_eq     = (rd_data == p);
  assign alu_joined = ({{GW{1'b0}}, alu_diff[CW-1:0]} <= {{CW{1'b0}}, gap_limit});

  // ram write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      gap_limit <= '0;
    end else begin
      occ <= occ_next;
      if (cfg_we) begin
        gap_limit <= cfg_wdata;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    kind  <= kind_next;
    p     <= p_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    pos   <= pos_next;
    idx   <= idx_next;
    s_idx <= s_idx_next;
    e_idx <= e_idx_next;
    cur   <= cur_next;
    ecur  <= ecur_next;
    size  <= size_next;
    rej   <= rej_next;
  end

  // sequencer: next state, register updates and ram control
  always_comb begin
    state_next = state;
    kind_next  = kind;
    p_next     = p;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    pos_next   = pos;
    idx_next   = idx;
    occ_next   = occ;
    s_idx_next = s_idx;
    e_idx_next = e_idx;
    cur_next   = cur;
    ecur_next  = ecur;
    size_next  = size;
    rej_next   = rej;
    mem_raddr  = mid[IW-1:0];
    mem_waddr  = idx[IW-1:0];
    mem_wdata  = rd_data;
    mem_we     = 1'b0;
    req.ready  = 1'b0;
    rsp.valid  = 1'b0;

    unique case (state)
      gcst_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          kind_next  = req.req_type;
          p_next     = p_in;
          lo_next    = '0;
          hi_next    = occ;
          rej_next   = 1'b0;
          size_next  = '0;
          state_next = gcst_pkg::ST_SRCH;
        end
      end

      // binary search for the count of points below p
      gcst_pkg::ST_SRCH: begin
        if (lo < hi) begin
          mid_next   = mid_sum[CNT-1:0];
          mem_raddr  = mid_sum[IW-1:0];
          state_next = gcst_pkg::ST_SCMP;
        end else begin
          pos_next   = lo;
          state_next = gcst_pkg::ST_PROBE;
        end
      end

      gcst_pkg::ST_SCMP: begin
        if (alu_lt) begin
          lo_next = mid + CNT'(1);
        end else begin
          hi_next = mid;
        end
        state_next = gcst_pkg::ST_SRCH;
      end

      // fetch the entry at the insertion point
      gcst_pkg::ST_PROBE: begin
        mem_raddr  = pos[IW-1:0];
        state_next = gcst_pkg::ST_PCHK;
      end

      gcst_pkg::ST_PCHK: begin
        if (kind == gcst_pkg::REQ_TOGGLE) begin
          size_next = '0;
          if (hit) begin
            idx_next   = pos;
            state_next = gcst_pkg::ST_DEL;
          end else if (occ >= CNT'(CAPACITY)) begin
            rej_next   = 1'b1;
            state_next = gcst_pkg::ST_OUT;
          end else begin
            idx_next   = occ;
            state_next = gcst_pkg::ST_INS;
          end
        end else begin
          if (top == '0) begin
            size_next  = '0;
            state_next = gcst_pkg::ST_OUT;
          end else begin
            s_idx_next = top_dec[IW-1:0];
            e_idx_next = top_dec[IW-1:0];
            size_next  = CNT'(1);
            state_next = gcst_pkg::ST_QLD;
          end
        end
      end

      // removal: move later entries down one place
      gcst_pkg::ST_DEL: begin
        if (idx_inc < CNT1'(occ)) begin
          mem_raddr  = idx_inc[IW-1:0];
          state_next = gcst_pkg::ST_DELW;
        end else begin
          occ_next   = occ - CNT'(1);
          state_next = gcst_pkg::ST_OUT;
        end
      end

      gcst_pkg::ST_DELW: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[IW-1:0];
        mem_wdata  = rd_data;
        idx_next   = idx_inc[CNT-1:0];
        state_next = gcst_pkg::ST_DEL;
      end

      // insertion: move entries up one place, then drop p in
      gcst_pkg::ST_INS: begin
        if (idx > pos) begin
          mem_raddr  = idx_dec[IW-1:0];
          state_next = gcst_pkg::ST_INSW;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = pos[IW-1:0];
          mem_wdata  = p;
          occ_next   = occ + CNT'(1);
          state_next = gcst_pkg::ST_OUT;
        end
      end

      gcst_pkg::ST_INSW: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[IW-1:0];
        mem_wdata  = rd_data;
        idx_next   = idx_dec;
        state_next = gcst_pkg::ST_INS;
      end

      // query: load the greatest point not above p
      gcst_pkg::ST_QLD: begin
        mem_raddr  = s_idx;
        state_next = gcst_pkg::ST_QLDW;
      end

      gcst_pkg::ST_QLDW: begin
        cur_next   = rd_data;
        ecur_next  = rd_data;
        state_next = gcst_pkg::ST_QBACK;
      end

      // walk down to the cluster start
      gcst_pkg::ST_QBACK: begin
        if (s_idx != '0) begin
          mem_raddr  = s_dec;
          state_next = gcst_pkg::ST_QBCHK;
        end else begin
          state_next = gcst_pkg::ST_QFWD;
        end
      end

      gcst_pkg::ST_QBCHK: begin
        if (alu_joined) begin
          s_idx_next = s_dec;
          cur_next   = rd_data;
          size_next  = size + CNT'(1);
          state_next = gcst_pkg::ST_QBACK;
        end else begin
          state_next = gcst_pkg::ST_QFWD;
        end
      end

      // walk up to the cluster end
      gcst_pkg::ST_QFWD: begin
        if (e_inc < CNT1'(occ)) begin
          mem_raddr  = e_inc[IW-1:0];
          state_next = gcst_pkg::ST_QFCHK;
        end else begin
          state_next = gcst_pkg::ST_OUT;
        end
      end

      gcst_pkg::ST_QFCHK: begin
        if (alu_joined) begin
          e_idx_next = e_inc[IW-1:0];
          ecur_next  = rd_data;
          size_next  = size + CNT'(1);
          state_next = gcst_pkg::ST_QFWD;
        end else begin
          state_next = gcst_pkg::ST_OUT;
        end
      end

      // hold the result until it is taken
      gcst_pkg::ST_OUT: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          state_next = gcst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = gcst_pkg::ST_IDLE;
      end
    endcase
  end

  // result fields
  assign size_wide        = {{SW{1'b0}}, size};
  assign rsp.cluster_size = size_wide[SW-1:0];
  assign rsp.rejected     = rej;

  // table never holds more than its capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT'(CAPACITY))
    else $error("occupancy above capacity");

  // the block never takes a request while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request accepted while result pending");

  // a rejected insert only happens on a full table
  a_rej_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.rejected |-> occ == CNT'(CAPACITY))
    else $error("insert rejected on a table with room");

  // occupancy moves only as an item finishes
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !$stable(occ) |-> state == gcst_pkg::ST_OUT)
    else $error("occupancy changed mid item");

  // search window stays ordered
  a_srch_window: assert property (@(posedge clk) disable iff (rst)
    state == gcst_pkg::ST_SRCH |-> lo <= hi)
    else $error("binary search window inverted");

endmodule

`default_nettype wire

FILE: tb/tb_gap_cluster_size_table_core.sv
// self-checking testbench for the gap cluster size table core
`timescale 1ns / 1ps

module tb_gap_cluster_size_table_core;

  localparam int          HALF_PERIOD  = 6;
  localparam int          TABLE_DEPTH  = gcst_pkg::CAPACITY_DEF;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int          MAX_REPORTS  = 40;

  typedef struct packed {
    logic [gcst_pkg::SIZE_W-1:0] size;
    logic                        rejected;
  } cluster_answer_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  logic [gcst_pkg::GAP_W-1:0]   cfg_wdata;

  gcst_req_if req_ch ();
  gcst_rsp_if rsp_ch ();

  gap_cluster_size_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // mirror of the table contents and the gap register
  logic [gcst_pkg::POINT_W-1:0] table_pts[$];
  logic [gcst_pkg::GAP_W-1:0]   gap_mirror;
  cluster_answer_t              answers_due[$];

  int send_idle_pct;
  int stall_pct;
  int errors;
  int toggles_sent;
  int queries_sent;
  int rejects_seen;
  int largest_cluster;
  int peak_occupancy;

  // clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic logic neighbors_joined(int lower);
    return (table_pts[lower + 1] - table_pts[lower]) <= gap_mirror;
  endfunction

  function automatic logic is_stored(logic [gcst_pkg::POINT_W-1:0] pt);
    foreach (table_pts[i]) if (table_pts[i] == pt) return 1'b1;
    return 1'b0;
  endfunction

  // apply one item to the mirror and return the answer it owes
  function automatic cluster_answer_t cluster_table_step(logic kind,
                                                         logic [gcst_pkg::POINT_W-1:0] pt);
    cluster_answer_t ans;
    int lo, hi, mid, top, s, e;
    logic hit;
    ans = '0;
    lo = 0;
    hi = table_pts.size();
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (table_pts[mid] < pt) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < table_pts.size()) && (table_pts[lo] == pt);
    if (kind == gcst_pkg::REQ_TOGGLE) begin
      if (hit) table_pts.delete(lo);
      else if (table_pts.size() >= TABLE_DEPTH) ans.rejected = 1'b1;
      else table_pts.insert(lo, pt);
    end else begin
      top = hit ? lo + 1 : lo;
      if (top > 0) begin
        s = top - 1;
        while (s > 0 && neighbors_joined(s - 1)) s--;
        e = s;
        while (e + 1 < table_pts.size() && neighbors_joined(e)) e++;
        ans.size = gcst_pkg::SIZE_W'(e - s + 1);
        if (e - s + 1 > largest_cluster) largest_cluster = e - s + 1;
      end
    end
    return ans;
  endfunction

  // drive one item, called at a falling edge, returns at a falling edge
  task automatic send_item(input logic kind, input logic [gcst_pkg::POINT_W-1:0] pt);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid    = 1'b0;
      req_ch.req_type = 1'($urandom);
      req_ch.point    = $urandom;
      @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.req_type = kind;
    req_ch.point    = pt;
    do @(posedge clk); while (!req_ch.ready);
    answers_due.push_back(cluster_table_step(kind, pt));
    if (kind == gcst_pkg::REQ_TOGGLE) toggles_sent++;
    else queries_sent++;
    if (answers_due[$].rejected) rejects_seen++;
    if (table_pts.size() > peak_occupancy) peak_occupancy = table_pts.size();
    @(negedge clk);
  endtask

  // wait until every owed answer has come back and the sequencer has settled
  task automatic drain();
    req_ch.valid = 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_gap(input logic [gcst_pkg::GAP_W-1:0] value);
    drain();
    cfg_we     = 1'b1;
    cfg_wdata  = value;
    @(negedge clk);
    cfg_we     = 1'b0;
    cfg_wdata  = $urandom;
    gap_mirror = value;
  endtask

  // receiver: random stalls, changed at the falling edge
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each result with the oldest owed answer
  always @(posedge clk) begin : check_results
    cluster_answer_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: cluster_size %0d rejected %0b", $time,
                   rsp_ch.cluster_size, rsp_ch.rejected);
      end else begin
        want = answers_due.pop_front();
        if (rsp_ch.cluster_size !== want.size) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: cluster_size expected %0d got %0d", $time, want.size,
                     rsp_ch.cluster_size);
        end
        if (rsp_ch.rejected !== want.rejected) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: rejected expected %0b got %0b", $time, want.rejected,
                     rsp_ch.rejected);
        end
      end
    end
  end

  // empty table, extreme coordinates, query below everything and in a gap
  task automatic test_empty_and_extremes();
    send_item(gcst_pkg::REQ_QUERY,  32'h0000_0000);
    send_item(gcst_pkg::REQ_QUERY,  32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_TOGGLE, 32'h0000_0000);
    send_item(gcst_pkg::REQ_QUERY,  32'h0000_0000);
    send_item(gcst_pkg::REQ_TOGGLE, 32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_QUERY,  32'h7FFF_FFFF);
    send_item(gcst_pkg::REQ_QUERY,  32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_TOGGLE, 32'h0000_0000);
    send_item(gcst_pkg::REQ_QUERY,  32'h0000_1234);
    send_item(gcst_pkg::REQ_TOGGLE, 32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_QUERY,  32'hFFFF_FFFF);
  endtask

  // neighbors joined exactly at the limit, split one past it
  task automatic test_cluster_joins();
    write_gap(32'd3);
    send_item(gcst_pkg::REQ_TOGGLE, 32'd10);
    send_item(gcst_pkg::REQ_TOGGLE, 32'd13);
    send_item(gcst_pkg::REQ_TOGGLE, 32'd17);
    send_item(gcst_pkg::REQ_TOGGLE, 32'd20);
    send_item(gcst_pkg::REQ_QUERY,  32'd9);
    send_item(gcst_pkg::REQ_QUERY,  32'd12);
    send_item(gcst_pkg::REQ_QUERY,  32'd16);
    send_item(gcst_pkg::REQ_QUERY,  32'd20);
    send_item(gcst_pkg::REQ_TOGGLE, 32'd13);
    send_item(gcst_pkg::REQ_QUERY,  32'd12);
    // widest gap joins the two ends of the coordinate range
    write_gap(32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_TOGGLE, 32'h0000_0000);
    send_item(gcst_pkg::REQ_TOGGLE, 32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_QUERY,  32'h8000_0000);
    write_gap(32'd0);
    send_item(gcst_pkg::REQ_QUERY,  32'd17);
  endtask

  // fill to capacity, inserts into a full table, removal from it, then shrink
  task automatic test_full_table();
    logic [gcst_pkg::POINT_W-1:0] base, pt;
    int n;
    write_gap(32'd2);
    base = $urandom_range(32'h0000_1000, 32'hFFFF_0000);
    n = 0;
    while (table_pts.size() < TABLE_DEPTH) begin
      pt = base + $urandom_range(0, 1023);
      if (!is_stored(pt)) send_item(gcst_pkg::REQ_TOGGLE, pt);
      if (++n % 8 == 0) send_item(gcst_pkg::REQ_QUERY, base + $urandom_range(0, 1023));
    end
    do pt = base + $urandom_range(0, 2047); while (is_stored(pt));
    send_item(gcst_pkg::REQ_TOGGLE, pt);
    send_item(gcst_pkg::REQ_TOGGLE, 32'h0000_0000);
    send_item(gcst_pkg::REQ_TOGGLE, 32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_QUERY,  32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_TOGGLE, table_pts[$urandom_range(TABLE_DEPTH - 1)]);
    send_item(gcst_pkg::REQ_TOGGLE, pt);
    send_item(gcst_pkg::REQ_TOGGLE, pt + 32'd4096);
    // every stored point in one cluster
    write_gap(32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    send_item(gcst_pkg::REQ_QUERY, table_pts[0]);
    write_gap(32'd1);
    while (table_pts.size() > 192) begin
      send_item(gcst_pkg::REQ_TOGGLE, table_pts[$urandom_range(table_pts.size() - 1)]);
      if ($urandom_range(3) == 0)
        send_item(gcst_pkg::REQ_QUERY, base + $urandom_range(0, 1023));
    end
  endtask

  // random toggles and queries around a window, under several idling mixes
  task automatic test_random_mix();
    int send_mix[5]  = '{0, 67, 0, 30, 0};
    int stall_mix[5] = '{0, 0, 67, 30, 0};
    logic [gcst_pkg::GAP_W-1:0]   gap_pick[5];
    logic [gcst_pkg::POINT_W-1:0] window, pt;
    logic                         kind;
    int                           pick;
    gap_pick = '{32'd0, 32'd1, $urandom_range(2, 16), 32'hFFFF_FFFF, $urandom};
    for (int ph = 0; ph < 5; ph++) begin
      write_gap(gap_pick[ph]);
      send_idle_pct = send_mix[ph];
      stall_pct     = stall_mix[ph];
      window        = $urandom;
      for (int i = 0; i < 40; i++) begin
        kind = ($urandom_range(99) < 40) ? gcst_pkg::REQ_QUERY : gcst_pkg::REQ_TOGGLE;
        pick = $urandom_range(99);
        if (pick < 35 && table_pts.size() > 0) begin
          pt = table_pts[$urandom_range(table_pts.size() - 1)];
          if (kind == gcst_pkg::REQ_QUERY) pt = pt + $urandom_range(0, 3);
        end else if (pick < 80) begin
          pt = window + $urandom_range(0, 255);
        end else if (pick < 92) begin
          pt = $urandom;
        end else begin
          pt = pick[0] ? 32'h0000_0000 : 32'hFFFF_FFFF;
        end
        send_item(kind, pt);
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // stimulus sequence
  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = gcst_pkg::REQ_TOGGLE;
    req_ch.point     = '0;
    gap_mirror       = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    errors           = 0;
    toggles_sent     = 0;
    queries_sent     = 0;
    rejects_seen     = 0;
    largest_cluster  = 0;
    peak_occupancy   = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_extremes();
    test_cluster_joins();
    test_full_table();
    test_random_mix();

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d toggles (%0d refused on a full table) and %0d queries",
             toggles_sent, rejects_seen, queries_sent);
    $display("gap limits 0 to all ones, peak occupancy %0d, largest cluster %0d",
             peak_occupancy, largest_cluster);
    if (errors == 0) begin
      $display("gap_cluster_size_table_core regression: pass");
    end else begin
      $display("gap_cluster_size_table_core regression: fail");
    end
    $finish;
  end

  // timeout
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("gap_cluster_size_table_core regression: fail");
    $finish;
  end

endmodule

FILE: gap_cluster_size_table_core.f
design/gcst_pkg.sv
design/gcst_req_if.sv
design/gcst_rsp_if.sv
design/gap_cluster_size_table_core.sv
tb/tb_gap_cluster_size_table_core.sv
